// ===== rtl/symbol_trie_hash_insert_macros.svh =====
// Assertion macros shared by the symbol trie hash insert block.
`ifndef SYMBOL_TRIE_HASH_INSERT_MACROS_SVH
`define SYMBOL_TRIE_HASH_INSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define STHI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define STHI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sthi_pkg.sv =====
// Types, constants and command codes shared by the symbol trie hash insert block.
package sthi_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 8;
   localparam int DIV_W       = $clog2(TABLE_DEPTH + (2**CHAR_W - 1) * (2**CHAR_W - 1));
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

   localparam logic [CHAR_W-1:0] RESERVED_CHAR = 8'h3F;
   localparam logic [LEN_W-1:0]  LEN_MAX       = '1;

   localparam logic REQ_HASH  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef logic [2:0] sthi_kind_type;

   localparam sthi_kind_type RES_WRITE = 3'd0;
   localparam sthi_kind_type RES_ZERO  = 3'd1;
   localparam sthi_kind_type RES_HIT   = 3'd2;
   localparam sthi_kind_type RES_NEW   = 3'd3;
   localparam sthi_kind_type RES_OVF   = 3'd4;

   typedef struct packed {
      logic [CHAR_W-1:0] chr;
      logic [IDX_W-1:0]  prefix;
   } sthi_entry_type;

   localparam int ENTRY_W = $bits(sthi_entry_type);

   typedef struct packed {
      logic          accept;
      logic          clear_step;
      logic          mod_start;
      logic          mod_sel;
      logic          latch_step;
      logic          latch_start;
      logic          advance;
      logic          finish;
      sthi_kind_type kind;
      logic          load_rsp;
   } sthi_cmd_type;

   typedef struct packed {
      logic is_write;
      logic ch_zero;
      logic mod_done;
      logic hit;
      logic empty;
      logic wrap;
      logic clear_last;
   } sthi_stat_type;

endpackage

// ===== rtl/sthi_if.sv =====
// Request and response channel interfaces of the symbol trie hash insert block.
interface sthi_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [sthi_pkg::CHAR_W-1:0]  ch;
   logic                         first_char;
   logic [sthi_pkg::IDX_W-1:0]   entry_index;
   logic [sthi_pkg::IDX_W-1:0]   entry_parent;

   modport source (output valid, req_type, ch, first_char, entry_index, entry_parent,
                   input ready);
   modport sink (input valid, req_type, ch, first_char, entry_index, entry_parent,
                 output ready);
endinterface

interface sthi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sthi_pkg::IDX_W-1:0]   node_index;
   logic [sthi_pkg::LEN_W-1:0]   symbol_length;
   logic                         was_new;
   logic                         overflow;

   modport source (output valid, node_index, symbol_length, was_new, overflow,
                   input ready);
   modport sink (input valid, node_index, symbol_length, was_new, overflow,
                 output ready);
endinterface

// ===== rtl/symbol_trie_hash_insert.sv =====
// Top level of the symbol trie hash insert block.
// After reset the block clears the table, one entry per cycle, and takes no request
// until that pass is over; table_size writes are taken throughout. One request is
// handled at a time. A write request or a hash request with a zero character goes
// from dispatch straight to the result state. A hash request runs the shared restoring
// remainder unit twice, once for the probe step and once for the start slot, at one bit
// per cycle, then takes each table probe through the address and check states, reading
// the registered read port. The result register lets the next request be transferred
// while the previous result still waits on the response channel.
`include "symbol_trie_hash_insert_macros.svh"

module symbol_trie_hash_insert (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [sthi_pkg::SIZE_W-1:0] csr_wdata,
   sthi_req_if.sink                    req_if,
   sthi_rsp_if.source                  rsp_if
);

   sthi_pkg::sthi_cmd_type  cmd;
   sthi_pkg::sthi_stat_type stat;

   sthi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sthi_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .in_req_type       (req_if.req_type),
      .in_ch             (req_if.ch),
      .in_first_char     (req_if.first_char),
      .in_entry_index    (req_if.entry_index),
      .in_entry_parent   (req_if.entry_parent),
      .cmd               (cmd),
      .stat              (stat),
      .out_node_index    (rsp_if.node_index),
      .out_symbol_length (rsp_if.symbol_length),
      .out_was_new       (rsp_if.was_new),
      .out_overflow      (rsp_if.overflow)
   );

   // A pending result is never overwritten before its transfer.
   `STHI_ASSERT_IMP(a_rsp_no_overwrite, cmd.load_rsp, (!rsp_if.valid || rsp_if.ready), "result overwritten before transfer")
   `STHI_ASSERT_NEXT(a_one_at_a_time, (req_if.valid && req_if.ready), !req_if.ready, "request taken while one is in flight")
   `STHI_ASSERT_NEXT(a_mod_busy, cmd.mod_start, !stat.mod_done, "remainder unit not busy after start")
   `STHI_ASSERT_IMP(a_claim_empty, (cmd.finish && cmd.kind == sthi_pkg::RES_NEW), (stat.empty && !stat.hit), "claimed entry not empty")

endmodule

// ===== rtl/sthi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sthi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sthi_mod.sv =====
// Restoring remainder unit that retires one dividend bit per cycle.
module sthi_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sthi_pkg::DIV_W-1:0]    dividend,
   input  logic [sthi_pkg::SIZE_W-1:0]   divisor,
   output logic                          done,
   output logic [sthi_pkg::SIZE_W-1:0]   remainder
);

   logic [sthi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sthi_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [sthi_pkg::DIV_W-1:0]     dvd_ff, dvd_in;
   logic [sthi_pkg::SIZE_W:0]      trial;
   logic [sthi_pkg::SIZE_W:0]      trial_sub;

   always_comb begin
      trial     = {rem_ff, dvd_ff[sthi_pkg::DIV_W-1]};
      trial_sub = trial - {1'b0, divisor};
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      if (start) begin
         cnt_in = sthi_pkg::DIV_CNT_W'(sthi_pkg::DIV_W);
         rem_in = '0;
         dvd_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[sthi_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_sub[sthi_pkg::SIZE_W-1:0];
         end else begin
            rem_in = trial[sthi_pkg::SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

// ===== rtl/sthi_dpath.sv =====
// Datapath: table memory, prefix and length state, probe arithmetic and result registers.
module sthi_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sthi_pkg::SIZE_W-1:0]   csr_wdata,
   input  logic                          in_req_type,
   input  logic [sthi_pkg::CHAR_W-1:0]   in_ch,
   input  logic                          in_first_char,
   input  logic [sthi_pkg::IDX_W-1:0]    in_entry_index,
   input  logic [sthi_pkg::IDX_W-1:0]    in_entry_parent,
   input  sthi_pkg::sthi_cmd_type        cmd,
   output sthi_pkg::sthi_stat_type       stat,
   output logic [sthi_pkg::IDX_W-1:0]    out_node_index,
   output logic [sthi_pkg::LEN_W-1:0]    out_symbol_length,
   output logic                          out_was_new,
   output logic                          out_overflow
);

   logic [sthi_pkg::SIZE_W-1:0] ts_ff, ts_in;
   logic [sthi_pkg::IDX_W-1:0]  cur_prefix_ff, cur_prefix_in;
   logic [sthi_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [sthi_pkg::IDX_W-1:0]  clr_ff, clr_in;

   logic                        type_ff, type_in;
   logic [sthi_pkg::CHAR_W-1:0] ch_ff, ch_in;
   logic [sthi_pkg::IDX_W-1:0]  prefix_ff, prefix_in;
   logic [sthi_pkg::LEN_W-1:0]  elen_ff, elen_in;
   logic [sthi_pkg::IDX_W-1:0]  widx_ff, widx_in;
   logic [sthi_pkg::IDX_W-1:0]  wpar_ff, wpar_in;
   logic [sthi_pkg::IDX_W-1:0]  step_ff, step_in;
   logic [sthi_pkg::IDX_W-1:0]  start_ff, start_in;
   logic [sthi_pkg::IDX_W-1:0]  slot_ff, slot_in;
   logic [sthi_pkg::IDX_W-1:0]  res_node_ff, res_node_in;
   logic [sthi_pkg::LEN_W-1:0]  res_len_ff, res_len_in;
   logic                        res_new_ff, res_new_in;
   logic                        res_ovf_ff, res_ovf_in;
   logic [sthi_pkg::IDX_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [sthi_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic                        rsp_new_ff, rsp_new_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic [sthi_pkg::SIZE_W-1:0]   size_act;
   logic [2*sthi_pkg::CHAR_W-1:0] ch_sq;
   logic [sthi_pkg::DIV_W-1:0]    dividend;
   logic                          mod_done;
   logic [sthi_pkg::SIZE_W-1:0]   remainder;
   logic [sthi_pkg::SIZE_W-1:0]   slot_sum;
   logic [sthi_pkg::SIZE_W-1:0]   slot_wrapped;
   logic [sthi_pkg::IDX_W-1:0]    slot_next;
   logic [sthi_pkg::LEN_W-1:0]    len_sat;
   logic                          widx_ok;

   logic                          ram_we;
   logic [sthi_pkg::IDX_W-1:0]    ram_waddr;
   sthi_pkg::sthi_entry_type      ram_wdata;
   sthi_pkg::sthi_entry_type      ram_rdata;

   always_comb begin
      if (ts_ff == '0 || ts_ff > sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH)) begin
         size_act = sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH);
      end else begin
         size_act = ts_ff;
      end
   end

   assign ch_sq = ch_ff * ch_ff;

   always_comb begin
      if (cmd.mod_sel) begin
         dividend = sthi_pkg::DIV_W'(prefix_ff) + sthi_pkg::DIV_W'(ch_sq);
      end else begin
         dividend = sthi_pkg::DIV_W'(ch_ff);
      end
   end

   sthi_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (dividend),
      .divisor   (size_act),
      .done      (mod_done),
      .remainder (remainder)
   );

   always_comb begin
      slot_sum     = {1'b0, slot_ff} + {1'b0, step_ff};
      slot_wrapped = slot_sum - size_act;
      if (slot_sum >= size_act) begin
         slot_next = slot_wrapped[sthi_pkg::IDX_W-1:0];
      end else begin
         slot_next = slot_sum[sthi_pkg::IDX_W-1:0];
      end
   end

   assign len_sat = (elen_ff == sthi_pkg::LEN_MAX) ? sthi_pkg::LEN_MAX : elen_ff + 1'b1;
   assign widx_ok = ({1'b0, widx_ff} < sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH));

   always_comb begin
      ram_we           = 1'b0;
      ram_waddr        = slot_ff;
      ram_wdata.chr    = ch_ff;
      ram_wdata.prefix = prefix_ff;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
         if (clr_ff == '0) begin
            ram_wdata.chr = sthi_pkg::RESERVED_CHAR;
         end
      end else if (cmd.finish && cmd.kind == sthi_pkg::RES_WRITE) begin
         ram_we           = widx_ok;
         ram_waddr        = widx_ff;
         ram_wdata.prefix = wpar_ff;
      end else if (cmd.finish && cmd.kind == sthi_pkg::RES_NEW) begin
         ram_we = 1'b1;
      end
   end

   sthi_ram #(
      .WIDTH (sthi_pkg::ENTRY_W),
      .DEPTH (sthi_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      ts_in         = csr_we ? csr_wdata : ts_ff;
      clr_in        = cmd.clear_step ? clr_ff + 1'b1 : clr_ff;
      cur_prefix_in = cur_prefix_ff;
      len_in        = len_ff;
      type_in       = type_ff;
      ch_in         = ch_ff;
      prefix_in     = prefix_ff;
      elen_in       = elen_ff;
      widx_in       = widx_ff;
      wpar_in       = wpar_ff;
      step_in       = step_ff;
      start_in      = start_ff;
      slot_in       = slot_ff;
      res_node_in   = res_node_ff;
      res_len_in    = res_len_ff;
      res_new_in    = res_new_ff;
      res_ovf_in    = res_ovf_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (cmd.accept) begin
         type_in   = in_req_type;
         ch_in     = in_ch;
         prefix_in = in_first_char ? '0 : cur_prefix_ff;
         elen_in   = in_first_char ? '0 : len_ff;
         widx_in   = in_entry_index;
         wpar_in   = in_entry_parent;
      end
      if (cmd.latch_step) begin
         step_in = remainder[sthi_pkg::IDX_W-1:0];
      end
      if (cmd.latch_start) begin
         start_in = remainder[sthi_pkg::IDX_W-1:0];
         slot_in  = remainder[sthi_pkg::IDX_W-1:0];
      end
      if (cmd.advance) begin
         slot_in = slot_next;
      end
      if (cmd.finish) begin
         res_new_in = 1'b0;
         res_ovf_in = 1'b0;
         case (cmd.kind)
            sthi_pkg::RES_WRITE: begin
               res_node_in = widx_ff;
               res_len_in  = len_ff;
            end
            sthi_pkg::RES_ZERO: begin
               cur_prefix_in = prefix_ff;
               len_in        = elen_ff;
               res_node_in   = prefix_ff;
               res_len_in    = elen_ff;
            end
            sthi_pkg::RES_HIT: begin
               cur_prefix_in = slot_ff;
               len_in        = len_sat;
               res_node_in   = slot_ff;
               res_len_in    = len_sat;
            end
            sthi_pkg::RES_NEW: begin
               cur_prefix_in = slot_ff;
               len_in        = len_sat;
               res_node_in   = slot_ff;
               res_len_in    = len_sat;
               res_new_in    = 1'b1;
            end
            default: begin
               res_node_in = '0;
               res_len_in  = len_ff;
               res_ovf_in  = 1'b1;
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_node_in = res_node_ff;
         rsp_len_in  = res_len_ff;
         rsp_new_in  = res_new_ff;
         rsp_ovf_in  = res_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff         <= sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH);
         cur_prefix_ff <= '0;
         len_ff        <= '0;
         clr_ff        <= '0;
      end else begin
         ts_ff         <= ts_in;
         cur_prefix_ff <= cur_prefix_in;
         len_ff        <= len_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      ch_ff       <= ch_in;
      prefix_ff   <= prefix_in;
      elen_ff     <= elen_in;
      widx_ff     <= widx_in;
      wpar_ff     <= wpar_in;
      step_ff     <= step_in;
      start_ff    <= start_in;
      slot_ff     <= slot_in;
      res_node_ff <= res_node_in;
      res_len_ff  <= res_len_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_node_ff <= rsp_node_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      stat.is_write   = (type_ff == sthi_pkg::REQ_WRITE);
      stat.ch_zero    = (ch_ff == '0);
      stat.mod_done   = mod_done;
      stat.hit        = (ram_rdata.chr == ch_ff) && (ram_rdata.prefix == prefix_ff);
      stat.empty      = (ram_rdata.chr == '0);
      stat.wrap       = (slot_next == start_ff);
      stat.clear_last = (clr_ff == sthi_pkg::IDX_W'(sthi_pkg::TABLE_DEPTH - 1));
   end

   assign out_node_index    = rsp_node_ff;
   assign out_symbol_length = rsp_len_ff;
   assign out_was_new       = rsp_new_ff;
   assign out_overflow      = rsp_ovf_ff;

endmodule

// ===== rtl/sthi_ctrl.sv =====
// Controller state machine that sequences clearing, division, probing and result transfer.
module sthi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sthi_pkg::sthi_stat_type stat,
   output sthi_pkg::sthi_cmd_type  cmd
);

   localparam logic [2:0] ST_CLEAR       = 3'd0;
   localparam logic [2:0] ST_IDLE        = 3'd1;
   localparam logic [2:0] ST_DISPATCH    = 3'd2;
   localparam logic [2:0] ST_WAIT_STEP   = 3'd3;
   localparam logic [2:0] ST_WAIT_START  = 3'd4;
   localparam logic [2:0] ST_PROBE_ADDR  = 3'd5;
   localparam logic [2:0] ST_PROBE_CHECK = 3'd6;
   localparam logic [2:0] ST_RESULT      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.is_write) begin
               cmd.finish = 1'b1;
               cmd.kind   = sthi_pkg::RES_WRITE;
               state_in   = ST_RESULT;
            end else if (stat.ch_zero) begin
               cmd.finish = 1'b1;
               cmd.kind   = sthi_pkg::RES_ZERO;
               state_in   = ST_RESULT;
            end else begin
               cmd.mod_start = 1'b1;
               state_in      = ST_WAIT_STEP;
            end
         end
         ST_WAIT_STEP: begin
            if (stat.mod_done) begin
               cmd.latch_step = 1'b1;
               cmd.mod_start  = 1'b1;
               cmd.mod_sel    = 1'b1;
               state_in       = ST_WAIT_START;
            end
         end
         ST_WAIT_START: begin
            cmd.mod_sel = 1'b1;
            if (stat.mod_done) begin
               cmd.latch_start = 1'b1;
               state_in        = ST_PROBE_ADDR;
            end
         end
         ST_PROBE_ADDR: begin
            state_in = ST_PROBE_CHECK;
         end
         ST_PROBE_CHECK: begin
            if (stat.hit) begin
               cmd.finish = 1'b1;
               cmd.kind   = sthi_pkg::RES_HIT;
               state_in   = ST_RESULT;
            end else if (stat.empty) begin
               cmd.finish = 1'b1;
               cmd.kind   = sthi_pkg::RES_NEW;
               state_in   = ST_RESULT;
            end else if (stat.wrap) begin
               cmd.finish = 1'b1;
               cmd.kind   = sthi_pkg::RES_OVF;
               state_in   = ST_RESULT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_PROBE_ADDR;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== dv/symbol_trie_hash_insert_test.sv =====
// Testbench for the symbol trie hash insert block: directed and random requests against a predictor.
module symbol_trie_hash_insert_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ERR_REPORTS = 10;
   localparam int WORD_COUNT  = 24;
   localparam int WORD_MAX    = 8;
   localparam int PHASE_ITEMS = 135;

   typedef struct packed {
      logic [sthi_pkg::IDX_W-1:0] node;
      logic [sthi_pkg::LEN_W-1:0] len;
      logic                       fresh;
      logic                       ovf;
   } node_result_type;

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        csr_we        = 1'b0;
   logic [sthi_pkg::SIZE_W-1:0] csr_wdata     = '0;
   logic                        req_valid_ff  = 1'b0;
   logic                        req_type_ff   = sthi_pkg::REQ_HASH;
   logic [sthi_pkg::CHAR_W-1:0] req_ch_ff     = '0;
   logic                        req_first_ff  = 1'b0;
   logic [sthi_pkg::IDX_W-1:0]  req_index_ff  = '0;
   logic [sthi_pkg::IDX_W-1:0]  req_parent_ff = '0;
   logic                        rsp_ready_ff  = 1'b0;

   sthi_req_if req_bus ();
   sthi_rsp_if rsp_bus ();

   assign req_bus.valid        = req_valid_ff;
   assign req_bus.req_type     = req_type_ff;
   assign req_bus.ch           = req_ch_ff;
   assign req_bus.first_char   = req_first_ff;
   assign req_bus.entry_index  = req_index_ff;
   assign req_bus.entry_parent = req_parent_ff;
   assign rsp_bus.ready        = rsp_ready_ff;

   symbol_trie_hash_insert u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the trie table, the symbol in progress and the table size.
   logic [sthi_pkg::CHAR_W-1:0] node_char   [sthi_pkg::TABLE_DEPTH];
   logic [sthi_pkg::IDX_W-1:0]  node_parent [sthi_pkg::TABLE_DEPTH];
   logic [sthi_pkg::IDX_W-1:0]  sym_prefix;
   logic [sthi_pkg::LEN_W-1:0]  sym_length;
   logic [sthi_pkg::SIZE_W-1:0] table_size;

   node_result_type expected_nodes [$];
   int              send_idle_pct  = 18;
   int              recv_idle_pct  = 77;
   int              mismatch_count = 0;
   int              cycle_count    = 0;

   logic [sthi_pkg::CHAR_W-1:0] word_text [WORD_COUNT][WORD_MAX];
   int                          word_len  [WORD_COUNT];

   function automatic node_result_type intern_char(input logic kind,
                                                   input logic [sthi_pkg::CHAR_W-1:0] c,
                                                   input logic first,
                                                   input logic [sthi_pkg::IDX_W-1:0] idx,
                                                   input logic [sthi_pkg::IDX_W-1:0] par);
      node_result_type            r;
      logic [sthi_pkg::IDX_W-1:0] prefix;
      logic [sthi_pkg::LEN_W-1:0] len;
      logic [sthi_pkg::LEN_W-1:0] next_len;
      int                         size;
      int                         start;
      int                         slot;
      r = '0;
      if (kind == sthi_pkg::REQ_WRITE) begin
         node_char[idx]   = c;
         node_parent[idx] = par;
         r.node = idx;
         r.len  = sym_length;
         return r;
      end
      prefix = first ? '0 : sym_prefix;
      len    = first ? '0 : sym_length;
      if (c == '0) begin
         sym_prefix = prefix;
         sym_length = len;
         r.node = prefix;
         r.len  = len;
         return r;
      end
      size = (table_size == 0 || table_size > sthi_pkg::TABLE_DEPTH) ?
             sthi_pkg::TABLE_DEPTH : int'(table_size);
      start = (int'(prefix) + int'(c) * int'(c)) % size;
      next_len = (len == sthi_pkg::LEN_MAX) ? len : len + 1'b1;
      slot = start;
      for (int t = 0; t < size; t++) begin
         if (node_char[slot] == c && node_parent[slot] == prefix) begin
            sym_prefix = sthi_pkg::IDX_W'(slot);
            sym_length = next_len;
            r.node = sthi_pkg::IDX_W'(slot);
            r.len  = next_len;
            return r;
         end
         if (node_char[slot] == '0) begin
            node_char[slot]   = c;
            node_parent[slot] = prefix;
            sym_prefix = sthi_pkg::IDX_W'(slot);
            sym_length = next_len;
            r.node  = sthi_pkg::IDX_W'(slot);
            r.len   = next_len;
            r.fresh = 1'b1;
            return r;
         end
         slot = (slot + int'(c)) % size;
         if (slot == start) break;
      end
      r.len = sym_length;
      r.ovf = 1'b1;
      return r;
   endfunction

   task automatic send_item(input logic kind, input logic [sthi_pkg::CHAR_W-1:0] c,
                            input logic first, input logic [sthi_pkg::IDX_W-1:0] idx,
                            input logic [sthi_pkg::IDX_W-1:0] par);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid_ff <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid_ff  <= 1'b1;
      req_type_ff   <= kind;
      req_ch_ff     <= c;
      req_first_ff  <= first;
      req_index_ff  <= idx;
      req_parent_ff <= par;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_nodes.push_back(intern_char(kind, c, first, idx, par));
   endtask

   task automatic wait_for_results();
      req_valid_ff <= 1'b0;
      while (expected_nodes.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_table_size(input logic [sthi_pkg::SIZE_W-1:0] value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      table_size = value;
   endtask

   function automatic logic [sthi_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(3))
         0: return sthi_pkg::SIZE_W'(256);
         1: return sthi_pkg::SIZE_W'(1024);
         2: return sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH);
         default: return sthi_pkg::SIZE_W'($urandom_range(256, sthi_pkg::TABLE_DEPTH));
      endcase
   endfunction

   task automatic build_words();
      int base;
      int keep;
      for (int w = 0; w < WORD_COUNT; w++) begin
         keep = 0;
         if (w > 0 && $urandom_range(1) == 1) begin
            base = $urandom_range(w - 1);
            keep = $urandom_range(1, word_len[base]);
            if (keep >= WORD_MAX) keep = WORD_MAX - 1;
            for (int i = 0; i < keep; i++) word_text[w][i] = word_text[base][i];
         end
         word_len[w] = $urandom_range(keep + 1, WORD_MAX);
         for (int i = keep; i < word_len[w]; i++) begin
            word_text[w][i] = sthi_pkg::CHAR_W'($urandom_range(1, 255));
         end
      end
   endtask

   task automatic send_word(input int w);
      for (int i = 0; i < word_len[w]; i++) begin
         send_item(sthi_pkg::REQ_HASH, word_text[w][i], i == 0,
                   sthi_pkg::IDX_W'($urandom_range(4095)),
                   sthi_pkg::IDX_W'($urandom_range(4095)));
      end
   endtask

   task automatic test_directed();
      send_item(sthi_pkg::REQ_HASH, 8'd1, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd255, 1'b0, 12'hFFF, 12'hFFF);
      send_item(sthi_pkg::REQ_HASH, 8'd1, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd255, 1'b0, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd0, 1'b0, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd0, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_WRITE, 8'd97, 1'b0, 12'd1217, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd97, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_WRITE, 8'd122, 1'b1, 12'd1412, 12'd5);
      send_item(sthi_pkg::REQ_HASH, 8'd98, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd98, 1'b0, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_WRITE, 8'd255, 1'b0, 12'hFFF, 12'hFFF);
      send_item(sthi_pkg::REQ_WRITE, sthi_pkg::RESERVED_CHAR, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_WRITE, 8'd0, 1'b0, 12'hAAA, 12'h555);
      send_item(sthi_pkg::REQ_WRITE, 8'hAA, 1'b1, 12'h555, 12'hAAA);
      send_item(sthi_pkg::REQ_HASH, sthi_pkg::RESERVED_CHAR, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd255, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd128, 1'b0, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd255, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd128, 1'b0, 12'h000, 12'h000);
   endtask

   task automatic test_table_size();
      set_table_size(sthi_pkg::SIZE_W'(256));
      send_item(sthi_pkg::REQ_WRITE, 8'd1, 1'b0, 12'd128, 12'd7);
      send_item(sthi_pkg::REQ_HASH, 8'd128, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd128, 1'b0, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_WRITE, 8'd5, 1'b0, 12'd4000, 12'd1);
      send_item(sthi_pkg::REQ_HASH, 8'd3, 1'b1, 12'h000, 12'h000);
      set_table_size(sthi_pkg::SIZE_W'(63));
      send_item(sthi_pkg::REQ_HASH, sthi_pkg::RESERVED_CHAR, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd1, 1'b0, 12'h000, 12'h000);
      set_table_size(sthi_pkg::SIZE_W'(1));
      send_item(sthi_pkg::REQ_HASH, 8'd97, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, sthi_pkg::RESERVED_CHAR, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd2, 1'b0, 12'h000, 12'h000);
      set_table_size(sthi_pkg::SIZE_W'(0));
      send_item(sthi_pkg::REQ_HASH, 8'd200, 1'b1, 12'h000, 12'h000);
      send_item(sthi_pkg::REQ_HASH, 8'd17, 1'b0, 12'h000, 12'h000);
      set_table_size('1);
      send_item(sthi_pkg::REQ_HASH, 8'd200, 1'b1, 12'h000, 12'h000);
      set_table_size(sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH + 1));
      send_item(sthi_pkg::REQ_HASH, 8'd17, 1'b0, 12'h000, 12'h000);
      set_table_size(sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH));
      send_item(sthi_pkg::REQ_HASH, 8'd200, 1'b1, 12'h000, 12'h000);
   endtask

   // A symbol longer than the length counter can hold.
   task automatic test_long_symbol();
      send_item(sthi_pkg::REQ_HASH, sthi_pkg::CHAR_W'($urandom_range(1, 255)), 1'b1,
                12'h000, 12'h000);
      for (int i = 0; i < 259; i++) begin
         send_item(sthi_pkg::REQ_HASH, sthi_pkg::CHAR_W'($urandom_range(1, 255)), 1'b0,
                   sthi_pkg::IDX_W'($urandom_range(4095)),
                   sthi_pkg::IDX_W'($urandom_range(4095)));
      end
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct);
      int sent;
      int next_pause;
      int w;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_table_size(pick_size());
      build_words();
      sent = 0;
      next_pause = 80;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            w = $urandom_range(WORD_COUNT - 1);
            send_word(w);
            sent += word_len[w];
         end else begin
            send_item(1'($urandom_range(1)), sthi_pkg::CHAR_W'($urandom_range(255)),
                      1'($urandom_range(1)), sthi_pkg::IDX_W'($urandom_range(4095)),
                      sthi_pkg::IDX_W'($urandom_range(4095)));
            sent++;
         end
         if (sent >= next_pause) begin
            next_pause += 80;
            if ($urandom_range(99) < 40) set_table_size(pick_size());
            else wait_for_results();
         end
      end
   endtask

   always @(posedge clock) begin
      node_result_type want;
      node_result_type got;
      if (!reset && rsp_bus.valid && rsp_ready_ff) begin
         got = {rsp_bus.node_index, rsp_bus.symbol_length, rsp_bus.was_new, rsp_bus.overflow};
         if (expected_nodes.size() == 0) begin
            if (mismatch_count < ERR_REPORTS)
               $display("unexpected result: node %0d len %0d new %0b ovf %0b",
                        got.node, got.len, got.fresh, got.ovf);
            mismatch_count++;
         end else begin
            want = expected_nodes.pop_front();
            if (got.node !== want.node || got.len !== want.len ||
                got.fresh !== want.fresh || got.ovf !== want.ovf) begin
               if (mismatch_count < ERR_REPORTS)
                  $display({"result differs: expected node %0d len %0d new %0b ovf %0b, ",
                            "got node %0d len %0d new %0b ovf %0b"},
                           want.node, want.len, want.fresh, want.ovf,
                           got.node, got.len, got.fresh, got.ovf);
               mismatch_count++;
            end
         end
      end
      rsp_ready_ff <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("symbol_trie_hash_insert: mismatch");
         $finish;
      end
   end

   initial begin
      foreach (node_char[i]) begin
         node_char[i]   = '0;
         node_parent[i] = '0;
      end
      node_char[0] = sthi_pkg::RESERVED_CHAR;
      sym_prefix   = '0;
      sym_length   = '0;
      table_size   = sthi_pkg::SIZE_W'(sthi_pkg::TABLE_DEPTH);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_size();
      test_long_symbol();
      test_random_phase(18, 77);
      test_random_phase(77, 18);
      test_random_phase(0, 0);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_nodes.size() == 0)
         $display("symbol_trie_hash_insert: match");
      else
         $display("symbol_trie_hash_insert: mismatch");
      $finish;
   end

endmodule
